// ===== sv/irpd_pkg.sv =====
// ----------------------------------------------------------------------------
// irpd_pkg
// Shared types and timing windows for the infrared remote pulse decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package irpd_pkg;

  localparam int unsigned IvW = 16;
  localparam int unsigned WordW = 32;
  localparam int unsigned CountW = 8;
  localparam int unsigned LimitW = 10;
  localparam int unsigned AddrW = 16;
  localparam int unsigned CmdW = 8;

  localparam int unsigned Nom560 = 560;
  localparam int unsigned Nom1680 = 1680;
  localparam int unsigned Nom2250 = 2250;
  localparam int unsigned Nom4500 = 4500;
  localparam int unsigned Nom9000 = 9000;

  localparam logic [IvW-1:0] Lo560 = IvW'((Nom560 * 3) / 4);
  localparam logic [IvW-1:0] Hi560 = IvW'((Nom560 * 5) / 4);
  localparam logic [IvW-1:0] Lo1680 = IvW'((Nom1680 * 3) / 4);
  localparam logic [IvW-1:0] Hi1680 = IvW'((Nom1680 * 5) / 4);
  localparam logic [IvW-1:0] Lo2250 = IvW'((Nom2250 * 3) / 4);
  localparam logic [IvW-1:0] Hi2250 = IvW'((Nom2250 * 5) / 4);
  localparam logic [IvW-1:0] Lo4500 = IvW'((Nom4500 * 3) / 4);
  localparam logic [IvW-1:0] Hi4500 = IvW'((Nom4500 * 5) / 4);
  localparam logic [IvW-1:0] Lo9000 = IvW'((Nom9000 * 3) / 4);
  localparam logic [IvW-1:0] Hi9000 = IvW'((Nom9000 * 5) / 4);

  localparam logic [CountW-1:0] FullCount = CountW'(WordW);
  localparam logic [LimitW-1:0] LimitReset = LimitW'(10);

  typedef struct packed {
    logic near_560;
    logic near_1680;
    logic near_2250;
    logic near_4500;
    logic near_9000;
  } class_t;

  typedef struct packed {
    logic             is_repeat;
    logic             leader_kind;
    logic [AddrW-1:0] address;
    logic [CmdW-1:0]  command;
  } result_t;

endpackage

`default_nettype wire

// ===== sv/irpd_window.sv =====
// ----------------------------------------------------------------------------
// irpd_window
// Classifies a measured interval against the five nominal pulse windows.
// ----------------------------------------------------------------------------
`default_nettype none

module irpd_window
  import irpd_pkg::*;
(
  input  var logic [IvW-1:0] interval_i,
  output class_t             class_o
);

  always_comb begin
    class_o.near_560  = (interval_i > Lo560)  && (interval_i < Hi560);
    class_o.near_1680 = (interval_i > Lo1680) && (interval_i < Hi1680);
    class_o.near_2250 = (interval_i > Lo2250) && (interval_i < Hi2250);
    class_o.near_4500 = (interval_i > Lo4500) && (interval_i < Hi4500);
    class_o.near_9000 = (interval_i > Lo9000) && (interval_i < Hi9000);
  end

endmodule

`default_nettype wire

// ===== sv/irpd_core.sv =====
// ----------------------------------------------------------------------------
// irpd_core
// Frame state machine: leader detection, bit shifting, word check and repeat.
// ----------------------------------------------------------------------------
`default_nettype none

module irpd_core
  import irpd_pkg::*;
#(
  parameter int unsigned OVERFLOW_CAP = 1000
) (
  input  var logic              clk_i,
  input  var logic              rst_ni,
  input  var logic              en_i,
  input  var logic              action_i,
  input  var logic              space_ended_i,
  input  var class_t            class_i,
  input  var logic [LimitW-1:0] repeat_limit_i,
  output logic                  res_valid_o,
  output result_t               res_o
);

  localparam int unsigned OvfW = $clog2(OVERFLOW_CAP + 2);
  localparam int unsigned CmpW = (OvfW > LimitW) ? OvfW : LimitW;

  typedef enum logic [1:0] {
    PH_IDLE    = 2'd0,
    PH_LEADER  = 2'd1,
    PH_RECEIVE = 2'd3
  } phase_e;

  phase_e             phase_q, phase_d;
  logic [WordW-1:0]   word_q, word_d;
  logic [CountW-1:0]  count_q, count_d;
  logic               kind_q, kind_d;
  logic [OvfW-1:0]    ovf_q, ovf_d;
  logic [AddrW-1:0]   last_addr_q, last_addr_d;
  logic [CmdW-1:0]    last_cmd_q, last_cmd_d;
  logic               last_kind_q, last_kind_d;

  logic [CmdW-1:0] lo_byte, hi_byte, cmd_byte, ncmd_byte;
  logic            repeat_ok;

  assign lo_byte   = word_d[7:0];
  assign hi_byte   = word_d[15:8];
  assign cmd_byte  = word_d[23:16];
  assign ncmd_byte = word_d[31:24];
  assign repeat_ok = CmpW'(ovf_q) < CmpW'(repeat_limit_i);

  always_comb begin
    phase_d     = phase_q;
    word_d      = word_q;
    count_d     = count_q;
    kind_d      = kind_q;
    ovf_d       = ovf_q;
    last_addr_d = last_addr_q;
    last_cmd_d  = last_cmd_q;
    last_kind_d = last_kind_q;
    res_valid_o = 1'b0;
    res_o       = '{is_repeat: 1'b0, leader_kind: last_kind_q,
                    address: last_addr_q, command: last_cmd_q};
    if (en_i) begin
      if (action_i) begin
        if (ovf_q <= OvfW'(OVERFLOW_CAP)) begin
          ovf_d = ovf_q + 1'b1;
        end
      end else if (!space_ended_i) begin
        if (class_i.near_560) begin
          phase_d = PH_RECEIVE;
        end else if (class_i.near_9000) begin
          phase_d = PH_LEADER;
          kind_d  = 1'b0;
        end else if (class_i.near_4500) begin
          phase_d = PH_LEADER;
          kind_d  = 1'b1;
        end else begin
          phase_d = PH_IDLE;
        end
      end else begin
        case (phase_q)
          PH_LEADER: begin
            count_d = '0;
            if (class_i.near_4500) begin
              phase_d = PH_RECEIVE;
            end else if (class_i.near_2250 && repeat_ok) begin
              ovf_d           = '0;
              res_valid_o     = 1'b1;
              res_o.is_repeat = 1'b1;
            end
          end
          PH_RECEIVE: begin
            word_d  = {class_i.near_1680 && !class_i.near_560, word_q[WordW-1:1]};
            count_d = (class_i.near_560 || class_i.near_1680) ? count_q + 1'b1 : '0;
            if ((count_d == FullCount) && (cmd_byte == ~ncmd_byte)) begin
              ovf_d       = '0;
              last_kind_d = kind_q;
              last_addr_d = (lo_byte == ~hi_byte) ? {8'h00, lo_byte} : word_d[15:0];
              last_cmd_d  = cmd_byte;
              res_valid_o = 1'b1;
              res_o       = '{is_repeat: 1'b0, leader_kind: last_kind_d,
                              address: last_addr_d, command: last_cmd_d};
            end
          end
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_IDLE;
      word_q      <= '0;
      count_q     <= '0;
      kind_q      <= 1'b0;
      ovf_q       <= '0;
      last_addr_q <= '0;
      last_cmd_q  <= '0;
      last_kind_q <= 1'b0;
    end else begin
      phase_q     <= phase_d;
      word_q      <= word_d;
      count_q     <= count_d;
      kind_q      <= kind_d;
      ovf_q       <= ovf_d;
      last_addr_q <= last_addr_d;
      last_cmd_q  <= last_cmd_d;
      last_kind_q <= last_kind_d;
    end
  end

  // A result is only ever produced for a request being processed.
  a_res_needs_en: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |-> en_i)
    else $error("result raised without a request");

  // Any result restarts the overflow count.
  a_res_clears_ovf: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |=> (ovf_q == '0))
    else $error("overflow count not cleared after a result");

  // A new frame leaves a full bit count behind; a repeat stays in the leader phase.
  a_frame_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && !res_o.is_repeat) |=> (count_q == FullCount))
    else $error("frame reported without a full word");

  a_repeat_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && res_o.is_repeat) |=> (phase_q == PH_LEADER))
    else $error("repeat reported outside the leader phase");

  // The overflow count saturates one above its cap.
  a_ovf_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ovf_q <= OvfW'(OVERFLOW_CAP + 1))
    else $error("overflow count beyond saturation");

endmodule

`default_nettype wire

// ===== sv/ir_remote_pulse_decoder.sv =====
// ----------------------------------------------------------------------------
// ir_remote_pulse_decoder
// Decodes NEC-style infrared frames and repeat codes from measured pulses.
// ----------------------------------------------------------------------------
//  Channel   Direction  Handshake             Payload
//  s_axis    in         tvalid/tready         edge or overflow request
//  m_axis    out        tvalid/tready         decoded frame or repeat
//  cfg       in         cfg_valid/cfg_ready   repeat_limit (10 bits)
//
//  One request is taken per cycle unless s_axis stalls; it waits in the
//  input register, and its result is registered on m_axis as it leaves.
//  Reset leaves the decoder idle with repeat_limit at 10; cfg is always ready.
//  When a result waits on m_axis, a request in the input register holds there
//  and s_axis stalls.
// ----------------------------------------------------------------------------
`default_nettype none

module ir_remote_pulse_decoder
  import irpd_pkg::*;
#(
  parameter int unsigned OVERFLOW_CAP = 1000
) (
  input  var logic              clk_i,
  input  var logic              rst_ni,
  input  var logic              s_axis_tvalid,
  output logic                  s_axis_tready,
  input  var logic [15:0]       s_axis_tdata,  // interval
  input  var logic [1:0]        s_axis_tuser,  // action, space_ended
  output logic                  m_axis_tvalid,
  input  var logic              m_axis_tready,
  output logic [23:0]           m_axis_tdata,  // address, command
  output logic [1:0]            m_axis_tuser,  // is_repeat, leader_kind
  input  var logic              cfg_valid_i,
  output logic                  cfg_ready_o,
  input  var logic [LimitW-1:0] cfg_data_i
);

  logic              in_valid_q;
  logic              action_q;
  logic              space_q;
  logic [IvW-1:0]    interval_q;
  logic [LimitW-1:0] limit_q;
  logic              out_valid_q;
  result_t           out_q;

  logic    advance;
  class_t  iv_class;
  logic    res_valid;
  result_t res;

  assign advance       = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;
  assign cfg_ready_o   = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      action_q   <= s_axis_tuser[0];
      space_q    <= s_axis_tuser[1];
      interval_q <= s_axis_tdata;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= LimitReset;
    end else if (cfg_valid_i) begin
      limit_q <= cfg_data_i;
    end
  end

  irpd_window u_window (
    .interval_i (interval_q),
    .class_o    (iv_class)
  );

  irpd_core #(
    .OVERFLOW_CAP (OVERFLOW_CAP)
  ) u_core (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .en_i           (advance),
    .action_i       (action_q),
    .space_ended_i  (space_q),
    .class_i        (iv_class),
    .repeat_limit_i (limit_q),
    .res_valid_o    (res_valid),
    .res_o          (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= res_valid;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && res_valid) begin
      out_q <= res;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {out_q.command, out_q.address};
  assign m_axis_tuser  = {out_q.leader_kind, out_q.is_repeat};

endmodule

`default_nettype wire
